>>> design/argus_shape_evaluator_macros.svh
// Assertion macros shared by the evaluator RTL.
`ifndef ARGUS_SHAPE_EVALUATOR_MACROS_SVH
`define ARGUS_SHAPE_EVALUATOR_MACROS_SVH

`ifndef SYNTHESIS
`define ASE_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("ase: implication check failed");
`define ASE_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("ase: next-cycle check failed");
`else
`define ASE_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define ASE_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif

`endif

>>> design/ase_pkg.sv
package ase_pkg;

  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned SQ_STEPS  = 32;
  localparam int unsigned EXP_TERMS = 12;

  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam logic [31:0] ONE_Q30   = 32'd1073741824;

  localparam logic [31:0] ENDPOINT_RST = 32'd65536;
  localparam logic [31:0] SLOPE_RST    = 32'd0;
  localparam logic [31:0] POWER_RST    = 32'd8388608;

  typedef enum logic [1:0] {
    REG_ENDPOINT = 2'd0,
    REG_SLOPE    = 2'd1,
    REG_POWER    = 2'd2
  } cfg_reg_t;

  // Sideband carried with every item down the pipe
  typedef struct packed {
    logic        vld;
    logic        beyond;
    logic [31:0] mass;
  } ase_tag_t;

  typedef struct packed {
    ase_tag_t    tag;
    logic [63:0] rem;
    logic [63:0] den;
    logic [31:0] q;
    logic        one;
  } div_row_t;

  typedef struct packed {
    ase_tag_t    tag;
    logic [31:0] x;
    logic [31:0] frac;
    logic [5:0]  k;
    logic [32:0] t2;
  } sq_row_t;

  typedef struct packed {
    ase_tag_t    tag;
    logic [30:0] term;
    logic [31:0] sum;
    logic [29:0] z;
    logic [16:0] yi;
  } ex_row_t;

  // ceil(2^(31+l)/k), l = ceil(log2 k): exact floor(a/k) for a < 2^31
  function automatic logic [31:0] recip_q(input logic [3:0] k);
    logic [31:0] r;
    case (k)
      4'd1:    r = 32'd2147483648;
      4'd2:    r = 32'd2147483648;
      4'd3:    r = 32'd2863311531;
      4'd4:    r = 32'd2147483648;
      4'd5:    r = 32'd3435973837;
      4'd6:    r = 32'd2863311531;
      4'd7:    r = 32'd2454267027;
      4'd8:    r = 32'd2147483648;
      4'd9:    r = 32'd3817748708;
      4'd10:   r = 32'd3435973837;
      4'd11:   r = 32'd3123612579;
      4'd12:   r = 32'd2863311531;
      default: r = 32'd2147483648;
    endcase
    return r;
  endfunction

  function automatic logic [5:0] recip_sh(input logic [3:0] k);
    logic [5:0] s;
    case (k)
      4'd1:    s = 6'd31;
      4'd2:    s = 6'd32;
      4'd3:    s = 6'd33;
      4'd4:    s = 6'd33;
      4'd5:    s = 6'd34;
      4'd6:    s = 6'd34;
      4'd7:    s = 6'd34;
      4'd8:    s = 6'd34;
      4'd9:    s = 6'd35;
      4'd10:   s = 6'd35;
      4'd11:   s = 6'd35;
      4'd12:   s = 6'd35;
      default: s = 6'd31;
    endcase
    return s;
  endfunction

  function automatic logic [30:0] div_small(input logic [30:0] a, input logic [3:0] k);
    logic [62:0] p;
    p = 63'(a) * 63'(recip_q(k));
    return 31'(p >> recip_sh(k));
  endfunction

endpackage

>>> design/argus_shape_evaluator.sv
// Channel   | Ports                        | Payload (lowest bit first)
// ----------+------------------------------+-----------------------------------
// in        | in_tvalid/in_tready/in_tdata | tdata[31:0] mass
// out       | out_tvalid/out_tready/...    | tdata[31:0] density;
//           |                              | tuser[0] beyond_endpoint, [1] saturated
// cfg       | cfg_valid/cfg_ready/...      | cfg_index register, cfg_data value
//
// One item enters per cycle while the output is not stalled; each result
// passes through the 32-step divider, the 32-step log squaring chain and
// the 12 two-stage Taylor terms. Reset (rst_n low, synchronous) empties the
// pipe and loads the register defaults. A stalled output freezes the whole
// pipe, so in_tready follows out_tready whenever a result is waiting.
`include "argus_shape_evaluator_macros.svh"

module argus_shape_evaluator (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [31:0]              in_tdata,   // [31:0] mass
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [31:0]              out_tdata,  // [31:0] density
  output logic [1:0]               out_tuser,  // [0] beyond_endpoint, [1] saturated
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  ase_pkg::cfg_reg_t        cfg_index,
  input  logic [31:0]              cfg_data
);
  import ase_pkg::*;

  // Configuration registers
  logic [31:0] endpoint_r, slope_r, power_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      endpoint_r <= ENDPOINT_RST;
      slope_r    <= SLOPE_RST;
      power_r    <= POWER_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ENDPOINT: endpoint_r <= cfg_data;
        REG_SLOPE:    slope_r    <= cfg_data;
        REG_POWER:    power_r    <= cfg_data;
        default:      ;  // drop writes beyond the register list
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // Slope as sign and magnitude
  logic        cneg;
  logic [31:0] cmag;
  assign cneg = slope_r[31];
  assign cmag = cneg ? 32'(33'h1_0000_0000 - 33'(slope_r)) : slope_r;

  // Global advance: the whole pipe moves unless a finished result is held
  logic out_vld_r;
  logic en;
  assign en        = !out_vld_r || out_tready;
  assign in_tready = en;

  // Stage 1: squares of mass and endpoint
  ase_tag_t    s1_tag_r, s1_tag_nxt;
  logic [63:0] msq_r, dsq_r, msq_nxt, dsq_nxt;

  always_comb begin
    s1_tag_nxt.vld    = in_tvalid;
    s1_tag_nxt.beyond = in_tdata >= endpoint_r;
    s1_tag_nxt.mass   = in_tdata;
    msq_nxt = 64'(in_tdata) * 64'(in_tdata);
    dsq_nxt = 64'(endpoint_r) * 64'(endpoint_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tag_r.vld <= 1'b0;
    end else if (en) begin
      s1_tag_r <= s1_tag_nxt;
      msq_r    <= msq_nxt;
      dsq_r    <= dsq_nxt;
    end
  end

  // Divider: one quotient bit of u = num/den per stage
  div_row_t dv_r [0:DIV_STEPS];
  div_row_t dv0_nxt;

  always_comb begin
    dv0_nxt.tag = s1_tag_r;
    dv0_nxt.rem = dsq_r - msq_r;
    dv0_nxt.den = dsq_r;
    dv0_nxt.q   = '0;
    dv0_nxt.one = (dsq_r - msq_r) >= dsq_r;  // mass zero: u is exactly one
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0].tag.vld <= 1'b0;
    end else if (en) begin
      dv_r[0] <= dv0_nxt;
    end
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    div_row_t    dv_nxt;
    logic [64:0] r2;
    logic        ge;
    always_comb begin
      r2 = {dv_r[i].rem, 1'b0};
      ge = r2 >= {1'b0, dv_r[i].den};
      dv_nxt     = dv_r[i];
      dv_nxt.rem = ge ? 64'(r2 - {1'b0, dv_r[i].den}) : r2[63:0];
      dv_nxt.q   = {dv_r[i].q[30:0], ge};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[i+1].tag.vld <= 1'b0;
      end else if (en) begin
        dv_r[i+1] <= dv_nxt;
      end
    end
  end

  // L0: normalise u for the log, and form c*u
  ase_tag_t    l0_tag_r;
  logic [31:0] l0_x_r, l0_x_nxt;
  logic [5:0]  l0_k_r, l0_k_nxt;
  logic [31:0] l0_cu_r, l0_cu_nxt;
  logic [32:0] u;
  logic [63:0] u_sh;
  logic [64:0] cu_full;

  always_comb begin
    u = dv_r[DIV_STEPS].one ? 33'h1_0000_0000 : {1'b0, dv_r[DIV_STEPS].q};
    l0_k_nxt = '0;
    for (int b = 0; b < 33; b++) begin
      if (u[b]) l0_k_nxt = 6'(b);
    end
    u_sh     = 64'(u) << (6'd31 - l0_k_nxt);
    l0_x_nxt = (l0_k_nxt == 6'd32) ? u[32:1] : u_sh[31:0];
    cu_full  = 65'(cmag) * 65'(u);
    l0_cu_nxt = cu_full[63:32];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l0_tag_r.vld <= 1'b0;
    end else if (en) begin
      l0_tag_r <= dv_r[DIV_STEPS].tag;
      l0_x_r   <= l0_x_nxt;
      l0_k_r   <= l0_k_nxt;
      l0_cu_r  <= l0_cu_nxt;
    end
  end

  // L1: c*u*log2(e), then the squaring chain for the log fraction
  sq_row_t     sq_r [0:SQ_STEPS];
  sq_row_t     sq0_nxt;
  logic [62:0] t2_full;

  always_comb begin
    t2_full      = 63'(l0_cu_r) * 63'(LOG2E_Q30);
    sq0_nxt.tag  = l0_tag_r;
    sq0_nxt.x    = l0_x_r;
    sq0_nxt.frac = '0;
    sq0_nxt.k    = l0_k_r;
    sq0_nxt.t2   = t2_full[62:30];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_r[0].tag.vld <= 1'b0;
    end else if (en) begin
      sq_r[0] <= sq0_nxt;
    end
  end

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sq
    sq_row_t     sq_nxt;
    logic [63:0] xx;
    logic [32:0] xs;
    always_comb begin
      xx = 64'(sq_r[i].x) * 64'(sq_r[i].x);
      xs = xx[63:31];
      sq_nxt      = sq_r[i];
      sq_nxt.x    = xs[32] ? xs[32:1] : xs[31:0];
      sq_nxt.frac = {sq_r[i].frac[30:0], xs[32]};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_r[i+1].tag.vld <= 1'b0;
      end else if (en) begin
        sq_r[i+1] <= sq_nxt;
      end
    end
  end

  // P1: negated log2(u) with 32 fraction bits
  ase_tag_t    p1_tag_r;
  logic [37:0] p1_nl_r, p1_nl_nxt;
  logic [32:0] p1_t2_r;

  assign p1_nl_nxt = {6'd32 - sq_r[SQ_STEPS].k, 32'd0} - 38'(sq_r[SQ_STEPS].frac);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_tag_r.vld <= 1'b0;
    end else if (en) begin
      p1_tag_r <= sq_r[SQ_STEPS].tag;
      p1_nl_r  <= p1_nl_nxt;
      p1_t2_r  <= sq_r[SQ_STEPS].t2;
    end
  end

  // P2: power times the log, integer and fraction halves
  ase_tag_t    p2_tag_r;
  logic [37:0] p2_ph_r, p2_ph_nxt;
  logic [31:0] p2_pl_r, p2_pl_nxt;
  logic [32:0] p2_t2_r;
  logic [63:0] pl_full;

  always_comb begin
    p2_ph_nxt = 38'(power_r) * 38'(p1_nl_r[37:32]);
    pl_full   = 64'(power_r) * 64'(p1_nl_r[31:0]);
    p2_pl_nxt = pl_full[63:32];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_tag_r.vld <= 1'b0;
    end else if (en) begin
      p2_tag_r <= p1_tag_r;
      p2_ph_r  <= p2_ph_nxt;
      p2_pl_r  <= p2_pl_nxt;
      p2_t2_r  <= p1_t2_r;
    end
  end

  // P3: exponent y in Q.24
  ase_tag_t    p3_tag_r;
  logic [40:0] p3_y_r, p3_y_nxt;
  logic [38:0] pmag;
  logic [40:0] tv;

  always_comb begin
    pmag     = 39'(p2_ph_r) + 39'(p2_pl_r);
    tv       = cneg ? 41'(-41'(p2_t2_r)) : 41'(p2_t2_r);
    p3_y_nxt = tv - 41'(pmag);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_tag_r.vld <= 1'b0;
    end else if (en) begin
      p3_tag_r <= p2_tag_r;
      p3_y_r   <= p3_y_nxt;
    end
  end

  // P4: split y, scale the fraction by ln2; Taylor terms follow
  ex_row_t     ex_r [0:EXP_TERMS];
  ex_row_t     mt_r [0:EXP_TERMS-1];
  ex_row_t     ex0_nxt;
  logic [53:0] z_full;

  always_comb begin
    z_full       = 54'(p3_y_r[23:0]) * 54'(LN2_Q30);
    ex0_nxt.tag  = p3_tag_r;
    ex0_nxt.term = 31'(ONE_Q30);
    ex0_nxt.sum  = ONE_Q30;
    ex0_nxt.z    = z_full[53:24];
    ex0_nxt.yi   = p3_y_r[40:24];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_r[0].tag.vld <= 1'b0;
    end else if (en) begin
      ex_r[0] <= ex0_nxt;
    end
  end

  for (genvar j = 0; j < EXP_TERMS; j++) begin : g_exp
    ex_row_t     mt_nxt, ex_nxt;
    logic [60:0] tz;
    logic [30:0] tq;
    always_comb begin
      tz = 61'(ex_r[j].term) * 61'(ex_r[j].z);
      mt_nxt      = ex_r[j];
      mt_nxt.term = tz[60:30];
      tq = div_small(mt_r[j].term, 4'(j + 1));
      ex_nxt      = mt_r[j];
      ex_nxt.term = tq;
      ex_nxt.sum  = mt_r[j].sum + 32'(tq);
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        mt_r[j].tag.vld   <= 1'b0;
        ex_r[j+1].tag.vld <= 1'b0;
      end else if (en) begin
        mt_r[j]   <= mt_nxt;
        ex_r[j+1] <= ex_nxt;
      end
    end
  end

  // PR: mass times mantissa
  ase_tag_t    pr_tag_r;
  logic [63:0] pr_prod_r, pr_prod_nxt;
  logic [16:0] pr_yi_r;

  assign pr_prod_nxt = 64'(ex_r[EXP_TERMS].tag.mass) * 64'(ex_r[EXP_TERMS].sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pr_tag_r.vld <= 1'b0;
    end else if (en) begin
      pr_tag_r  <= ex_r[EXP_TERMS].tag;
      pr_prod_r <= pr_prod_nxt;
      pr_yi_r   <= ex_r[EXP_TERMS].yi;
    end
  end

  // Output stage: scale by 2^(yi-30), clamp on overflow, zero beyond the endpoint
  logic [31:0]        out_data_r, out_data_nxt;
  logic               out_beyond_r, out_sat_r, out_sat_nxt;
  logic signed [17:0] s;
  logic [17:0]        sh_n;
  logic [63:0]        rr;

  always_comb begin
    s            = $signed({pr_yi_r[16], pr_yi_r}) - 18'sd30;
    sh_n         = 18'(-s);
    rr           = pr_prod_r >> sh_n[5:0];
    out_data_nxt = '0;
    out_sat_nxt  = 1'b0;
    if (pr_tag_r.beyond || pr_prod_r == 64'd0) begin
      out_data_nxt = '0;
    end else if (!s[17]) begin
      if (s >= 18'sd32 || (pr_prod_r >> (6'd32 - 6'(s[4:0]))) != 64'd0) begin
        out_data_nxt = '1;
        out_sat_nxt  = 1'b1;
      end else begin
        out_data_nxt = 32'(pr_prod_r << s[4:0]);
      end
    end else if (sh_n >= 18'd64) begin
      out_data_nxt = '0;
    end else if (rr[63:32] != 32'd0) begin
      out_data_nxt = '1;
      out_sat_nxt  = 1'b1;
    end else begin
      out_data_nxt = rr[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r    <= pr_tag_r.vld;
      out_data_r   <= out_data_nxt;
      out_beyond_r <= pr_tag_r.beyond;
      out_sat_r    <= out_sat_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = {out_sat_r, out_beyond_r};

  `ASE_ASSERT_IMP(a_beyond_zero, clk, rst_n, out_vld_r && out_beyond_r, out_data_r == 32'd0 && !out_sat_r)
  `ASE_ASSERT_IMP(a_sat_clamped, clk, rst_n, out_vld_r && out_sat_r, out_data_r == 32'hFFFF_FFFF)
  `ASE_ASSERT_IMP(a_log_norm, clk, rst_n, sq_r[0].tag.vld && !sq_r[0].tag.beyond, sq_r[0].x[31])
  `ASE_ASSERT_IMP(a_mant_floor, clk, rst_n, ex_r[EXP_TERMS].tag.vld, ex_r[EXP_TERMS].sum >= ONE_Q30)

endmodule
